>>> hw/rtl/hls_pkg.sv
// ----------------------------------------------------------------------------
// hls_pkg
// Shared types, constants and helper functions of the heater link supervisor.
// ----------------------------------------------------------------------------
package hls_pkg;

  // frame geometry
  localparam int FrameBytes = 20;
  localparam int PayloadLen = FrameBytes - 2;
  localparam int PosW       = $clog2(FrameBytes);
  localparam int IdxW       = $clog2(PayloadLen);
  localparam int NumBanks   = 2;
  localparam int BufDepth   = NumBanks * PayloadLen;
  localparam int BufAddrW   = $clog2(BufDepth);

  // queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // crc
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // field widths
  localparam int ErrW     = 8;
  localparam int RunonW   = 16;
  localparam int RebootW  = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [ErrW-1:0]    ErrMax   = '1;
  localparam logic [RunonW-1:0]  RunonMax = '1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgDevAddr     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxErrors   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFanRunon    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRebootTicks = 2'd3;

  // op codes
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // result kinds
  localparam logic KindStatus  = 1'b0;
  localparam logic KindPayload = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       heater_on;
  } hls_in_t;

  typedef struct packed {
    logic            kind;
    logic [7:0]      payload_byte;
    logic            last;
    logic            frame_accepted;
    logic [ErrW-1:0] error_count;
    logic            fan_on;
    logic            relay_on;
  } hls_out_t;

  // one queued job: a status result or a burst of payload bytes
  typedef struct packed {
    logic            is_burst;
    logic            bank;
    logic [ErrW-1:0] error_count;
    logic            fan_on;
    logic            relay_on;
  } hls_job_t;

  typedef struct packed {
    logic            en;
    logic            bank;
    logic [IdxW-1:0] idx;
    logic [7:0]      data;
  } hls_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } hls_rel_t;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // buffer position read for output slot k
  function automatic logic [IdxW-1:0] source_index(logic [IdxW-1:0] k);
    int kk;
    int partner;
    int hi;
    kk = int'(k);
    if (kk == PayloadLen - 2) return IdxW'(PayloadLen - 1);
    if (kk == PayloadLen - 1) return IdxW'(PayloadLen - 2);
    if (kk >= 1 && kk <= 6) begin
      partner = kk[0] ? kk + 1 : kk - 1;
      hi = (kk > partner) ? kk : partner;
      if (hi < PayloadLen - 2) return IdxW'(partner);
    end
    return k;
  endfunction

  function automatic logic [BufAddrW-1:0] buf_addr(logic bank, logic [IdxW-1:0] idx);
    return bank ? BufAddrW'(PayloadLen) + BufAddrW'(idx) : BufAddrW'(idx);
  endfunction

endpackage

>>> hw/rtl/heater_link_supervisor_core.sv
// ----------------------------------------------------------------------------
// heater_link_supervisor_core
// Link frame checker (crc-16, address) with fan run-on and relay supervisor.
// ----------------------------------------------------------------------------
// usage:
//   in channel: one item per handshake, either a received link byte (op 0,
//   with frame_start marking byte 0) or a one-second tick (op 1).
//   out channel: every item yields one status result, except the last byte
//   of a frame with good crc and matching address, which yields 18 payload
//   results (last set on the final one).
//   cfg channel: always ready, register index plus data, written while idle.
// timing:
//   one item per cycle; the front does one table-free crc byte step per
//   cycle and the back drives one result per cycle from the output register.
//   the first result of an item is registered in the job queue and then in
//   the output register.
//   a 4-deep job queue sits between front and back; the frame buffer has two
//   banks, so input stalls when the queue is full or when a third frame
//   would need a bank whose payload is still being drained.
// reset: all state returns to its idle values, fan on, relay off, buffer
//   contents left as they are (always rewritten before being read).
// a stalled receiver holds the current result and backs up into the queue.
// ----------------------------------------------------------------------------
module heater_link_supervisor_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  hls_pkg::hls_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output hls_pkg::hls_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hls_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [hls_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  hls_pkg::hls_job_t q_push_data;
  hls_pkg::hls_job_t q_head;
  hls_pkg::hls_wr_t  buf_wr;
  hls_pkg::hls_rel_t bank_rel;

  hls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_push_data),
    .wr_o        (buf_wr),
    .rel_i       (bank_rel)
  );

  hls_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  hls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (buf_wr),
    .head_i      (q_head),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .rel_o       (bank_rel),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // queue never overflows or underflows
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> (!q_full || q_pop))
    else $error("job queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("job queue underflow");

  // payload results only come from accepted frames, which clear the error count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == hls_pkg::KindPayload) |->
    (out_data_o.frame_accepted && out_data_o.error_count == '0))
    else $error("payload result without accepted frame");

  // a bank is released only when its last byte goes out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_rel.en |=> (out_valid_o && out_data_o.last && out_data_o.kind == hls_pkg::KindPayload))
    else $error("frame bank released early");

endmodule

>>> hw/rtl/hls_queue.sv
// ----------------------------------------------------------------------------
// hls_queue
// Small job queue between the front (classify) and back (emit) parts.
// ----------------------------------------------------------------------------
module hls_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hls_pkg::hls_job_t push_data_i,
  input  logic              pop_i,
  output hls_pkg::hls_job_t head_o,
  output logic              empty_o,
  output logic              full_o
);

  hls_pkg::hls_job_t              mem_q [hls_pkg::QDepth];
  logic [hls_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [hls_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [hls_pkg::QCntW-1:0]      cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == hls_pkg::QCntW'(hls_pkg::QDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == hls_pkg::QPtrW'(hls_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == hls_pkg::QPtrW'(hls_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/hls_front.sv
// ----------------------------------------------------------------------------
// hls_front
// Accepts items, runs frame position and crc, the error count and the tick
// supervisor, writes frame bytes and queues one job per item.
// ----------------------------------------------------------------------------
module hls_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  hls_pkg::hls_in_t               in_data_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hls_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [hls_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output hls_pkg::hls_job_t              q_data_o,
  output hls_pkg::hls_wr_t               wr_o,
  input  hls_pkg::hls_rel_t              rel_i
);

  logic [7:0]                    dev_addr_q;
  logic [hls_pkg::ErrW-1:0]      max_err_q;
  logic [hls_pkg::RunonW-1:0]    runon_ticks_q;
  logic [hls_pkg::RebootW-1:0]   reboot_ticks_q;

  logic [hls_pkg::PosW-1:0]      pos_q, pos_d, pos_eff;
  logic [15:0]                   crc_q, crc_d, crc_eff;
  logic [7:0]                    crc_hi_q, crc_hi_d;
  logic [7:0]                    addr0_q, addr0_d;
  logic [hls_pkg::ErrW-1:0]      err_q, err_d;
  logic [hls_pkg::RunonW-1:0]    runon_q, runon_d;
  logic                          fan_q, fan_d;
  logic                          relay_q, relay_d;
  logic [hls_pkg::RebootW-1:0]   reboot_q, reboot_d;
  logic                          wr_bank_q, wr_bank_d;
  logic [hls_pkg::NumBanks-1:0]  busy_q, busy_d;

  logic accept;
  logic burst;
  logic crc_good;

  assign cfg_ready_o = 1'b1;
  // stall while the queue is full or the bank to be filled still waits to be drained
  assign in_ready_o  = !q_full_i && !busy_q[wr_bank_q];
  assign accept      = in_valid_i && in_ready_o;

  assign pos_eff  = in_data_i.frame_start ? '0 : pos_q;
  assign crc_eff  = in_data_i.frame_start ? hls_pkg::CrcInit : crc_q;
  assign crc_good = ({crc_hi_q, in_data_i.rx_byte} == crc_eff);

  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    crc_hi_d  = crc_hi_q;
    addr0_d   = addr0_q;
    err_d     = err_q;
    runon_d   = runon_q;
    fan_d     = fan_q;
    relay_d   = relay_q;
    reboot_d  = reboot_q;
    wr_bank_d = wr_bank_q;
    busy_d    = busy_q;
    burst     = 1'b0;
    wr_o.en   = 1'b0;
    wr_o.bank = wr_bank_q;
    wr_o.idx  = pos_eff[hls_pkg::IdxW-1:0];
    wr_o.data = in_data_i.rx_byte;

    if (rel_i.en) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept) begin
      if (in_data_i.op == hls_pkg::OpTick) begin
        if (reboot_q != '0) begin
          reboot_d = reboot_q - 1'b1;
          if (reboot_q == hls_pkg::RebootW'(1)) begin
            relay_d = 1'b1;
            err_d   = '0;
          end
        end else if (in_data_i.heater_on) begin
          fan_d   = 1'b1;
          runon_d = '0;
          if (err_q >= max_err_q) begin
            relay_d  = 1'b0;
            reboot_d = (reboot_ticks_q != '0) ? reboot_ticks_q : hls_pkg::RebootW'(1);
          end else begin
            relay_d = 1'b1;
          end
        end else begin
          relay_d = 1'b0;
          if (runon_q <= runon_ticks_q) begin
            if (runon_q != hls_pkg::RunonMax) begin
              runon_d = runon_q + 1'b1;
            end
          end else begin
            fan_d = 1'b0;
          end
        end
      end else begin
        if (pos_eff < hls_pkg::PosW'(hls_pkg::PayloadLen)) begin
          wr_o.en = 1'b1;
          crc_d   = hls_pkg::crc_step(crc_eff, in_data_i.rx_byte);
          pos_d   = pos_eff + 1'b1;
          if (pos_eff == '0) begin
            addr0_d = in_data_i.rx_byte;
          end
        end else if (pos_eff == hls_pkg::PosW'(hls_pkg::PayloadLen)) begin
          crc_d    = crc_eff;
          crc_hi_d = in_data_i.rx_byte;
          pos_d    = pos_eff + 1'b1;
        end else begin
          pos_d = '0;
          crc_d = hls_pkg::CrcInit;
          if (crc_good) begin
            // good crc but foreign address: frame dropped silently
            if (addr0_q == dev_addr_q) begin
              err_d             = '0;
              burst             = 1'b1;
              busy_d[wr_bank_q] = 1'b1;
              wr_bank_d         = ~wr_bank_q;
            end
          end else if (in_data_i.heater_on) begin
            if (err_q != hls_pkg::ErrMax) begin
              err_d = err_q + 1'b1;
            end
          end else begin
            err_d = '0;
          end
        end
      end
    end
  end

  assign q_push_o             = accept;
  assign q_data_o.is_burst    = burst;
  assign q_data_o.bank        = wr_bank_q;
  assign q_data_o.error_count = err_d;
  assign q_data_o.fan_on      = fan_d;
  assign q_data_o.relay_on    = relay_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q     <= 8'd1;
      max_err_q      <= hls_pkg::ErrW'(5);
      runon_ticks_q  <= hls_pkg::RunonW'(60);
      reboot_ticks_q <= hls_pkg::RebootW'(3);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hls_pkg::CfgDevAddr:     dev_addr_q     <= cfg_data_i[7:0];
        hls_pkg::CfgMaxErrors:   max_err_q      <= cfg_data_i[hls_pkg::ErrW-1:0];
        hls_pkg::CfgFanRunon:    runon_ticks_q  <= cfg_data_i[hls_pkg::RunonW-1:0];
        hls_pkg::CfgRebootTicks: reboot_ticks_q <= cfg_data_i[hls_pkg::RebootW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      crc_q     <= hls_pkg::CrcInit;
      crc_hi_q  <= '0;
      addr0_q   <= '0;
      err_q     <= '0;
      runon_q   <= '0;
      fan_q     <= 1'b1;
      relay_q   <= 1'b0;
      reboot_q  <= '0;
      wr_bank_q <= 1'b0;
      busy_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      crc_hi_q  <= crc_hi_d;
      addr0_q   <= addr0_d;
      err_q     <= err_d;
      runon_q   <= runon_d;
      fan_q     <= fan_d;
      relay_q   <= relay_d;
      reboot_q  <= reboot_d;
      wr_bank_q <= wr_bank_d;
      busy_q    <= busy_d;
    end
  end

endmodule

>>> hw/rtl/hls_back.sv
// ----------------------------------------------------------------------------
// hls_back
// Holds the two-bank frame buffer, pops jobs and drives the result register,
// one result per cycle while the receiver keeps up, walking accepted frames in swapped order.
// ----------------------------------------------------------------------------
module hls_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hls_pkg::hls_wr_t  wr_i,
  input  hls_pkg::hls_job_t head_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output hls_pkg::hls_rel_t rel_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hls_pkg::hls_out_t out_data_o
);

  logic [7:0] buf_mem [hls_pkg::BufDepth];

  logic                          burst_act_q;
  logic                          burst_bank_q;
  logic [hls_pkg::IdxW-1:0]      burst_k_q;
  logic [hls_pkg::ErrW-1:0]      burst_err_q;
  logic                          burst_fan_q;
  logic                          burst_relay_q;

  logic                          out_valid_q;
  logic                          out_kind_q;
  logic                          out_last_q;
  logic                          out_acc_q;
  logic [hls_pkg::ErrW-1:0]      out_err_q;
  logic                          out_fan_q;
  logic                          out_relay_q;
  logic [7:0]                    rd_q;

  logic                          advance;
  logic                          emit;
  logic                          last_k;
  logic                          rd_en;
  logic                          rd_bank;
  logic [hls_pkg::IdxW-1:0]      rd_idx;

  // output register frees when empty or taken
  assign advance = !out_valid_q || out_ready_i;
  assign emit    = burst_act_q || !q_empty_i;
  assign q_pop_o = advance && !burst_act_q && !q_empty_i;
  assign last_k  = (burst_k_q == hls_pkg::IdxW'(hls_pkg::PayloadLen - 1));

  assign rd_bank = burst_act_q ? burst_bank_q : head_i.bank;
  assign rd_idx  = burst_act_q ? hls_pkg::source_index(burst_k_q)
                               : hls_pkg::source_index('0);
  assign rd_en   = advance && (burst_act_q || (!q_empty_i && head_i.is_burst));

  assign rel_o.en   = advance && burst_act_q && last_k;
  assign rel_o.bank = burst_bank_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      buf_mem[hls_pkg::buf_addr(wr_i.bank, wr_i.idx)] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= buf_mem[hls_pkg::buf_addr(rd_bank, rd_idx)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      burst_act_q <= 1'b0;
      burst_k_q   <= '0;
    end else if (advance) begin
      out_valid_q <= emit;
      if (burst_act_q) begin
        if (last_k) begin
          burst_act_q <= 1'b0;
        end
        burst_k_q <= burst_k_q + 1'b1;
      end else if (!q_empty_i && head_i.is_burst) begin
        burst_act_q <= 1'b1;
        burst_k_q   <= hls_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (burst_act_q) begin
        out_kind_q  <= hls_pkg::KindPayload;
        out_last_q  <= last_k;
        out_acc_q   <= 1'b1;
        out_err_q   <= burst_err_q;
        out_fan_q   <= burst_fan_q;
        out_relay_q <= burst_relay_q;
      end else begin
        out_kind_q  <= head_i.is_burst ? hls_pkg::KindPayload : hls_pkg::KindStatus;
        out_last_q  <= !head_i.is_burst;
        out_acc_q   <= head_i.is_burst;
        out_err_q   <= head_i.error_count;
        out_fan_q   <= head_i.fan_on;
        out_relay_q <= head_i.relay_on;
      end
      if (q_pop_o) begin
        burst_bank_q  <= head_i.bank;
        burst_err_q   <= head_i.error_count;
        burst_fan_q   <= head_i.fan_on;
        burst_relay_q <= head_i.relay_on;
      end
    end
  end

  assign out_valid_o                = out_valid_q;
  assign out_data_o.kind            = out_kind_q;
  assign out_data_o.payload_byte    = (out_kind_q == hls_pkg::KindPayload) ? rd_q : 8'h00;
  assign out_data_o.last            = out_last_q;
  assign out_data_o.frame_accepted  = out_acc_q;
  assign out_data_o.error_count     = out_err_q;
  assign out_data_o.fan_on          = out_fan_q;
  assign out_data_o.relay_on        = out_relay_q;

endmodule

>>> tb/tb_heater_link_supervisor_core.sv
// ----------------------------------------------------------------------------
// tb_heater_link_supervisor_core
// Self-checking bench for the link frame checker and heater supervisor. A
// cycle-free predictor follows every accepted item (link bytes and ticks)
// and queues the results it should cause; each result leaving the block is
// compared field by field against the oldest queued one. Directed tests
// cover frame acceptance, crc errors, address mismatch, resync, reboots and
// fan run-on; random phases then mix well-formed frames with corrupted,
// truncated and stray items under changing register values.
// ----------------------------------------------------------------------------
module tb_heater_link_supervisor_core;

  localparam int CycleLimit  = 2_000_000;
  localparam int DrainCycles = 8;

  // payload fill patterns for generated frames
  localparam int FillRandom = 0;
  localparam int FillRamp   = 1;
  localparam int FillZeros  = 2;
  localparam int FillOnes   = 3;

  typedef enum logic [1:0] {RdyAlways, RdyCoin, RdySparse, RdyBeat} rdy_mode_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  hls_pkg::hls_in_t             in_data_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  hls_pkg::hls_out_t            out_data_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [hls_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [hls_pkg::CfgDataW-1:0] cfg_data_i;

  heater_link_supervisor_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted register values and supervisor state
  logic [7:0]  sup_dev_addr;
  logic [7:0]  sup_max_errors;
  logic [15:0] sup_runon_len;
  logic [3:0]  sup_reboot_len;
  int          sup_pos;
  logic [15:0] sup_crc;
  logic [7:0]  sup_crc_hi;
  logic [7:0]  sup_frame [hls_pkg::PayloadLen];
  logic [7:0]  sup_errors;
  logic [15:0] sup_runon;
  logic        sup_fan;
  logic        sup_relay;
  logic [3:0]  sup_reboot_cnt;

  hls_pkg::hls_out_t pending_results [$];
  hls_pkg::hls_out_t oldest_result;
  int          n_fail;
  int          n_sent;
  int          burst_left;

  rdy_mode_e   ready_mode = RdyAlways;
  int          ready_hold = 0;
  logic [2:0]  beat_cnt   = '0;

  function automatic logic [15:0] crc_next(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ hls_pkg::CrcPoly) : (c >> 1);
    return c;
  endfunction

  // buffer slot shown at output position k
  function automatic int slot_source(int k);
    int hi;
    hi = (k % 2 == 1) ? k + 1 : k;
    if (k == hls_pkg::PayloadLen - 2) return hls_pkg::PayloadLen - 1;
    if (k == hls_pkg::PayloadLen - 1) return hls_pkg::PayloadLen - 2;
    if (k >= 1 && k <= 6 && hi < hls_pkg::PayloadLen - 2) return (k % 2 == 1) ? k + 1 : k - 1;
    return k;
  endfunction

  function automatic void push_result(logic kind, logic [7:0] pay, logic last, logic acc);
    hls_pkg::hls_out_t r;
    r.kind           = kind;
    r.payload_byte   = pay;
    r.last           = last;
    r.frame_accepted = acc;
    r.error_count    = sup_errors;
    r.fan_on         = sup_fan;
    r.relay_on       = sup_relay;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_item(hls_pkg::hls_in_t it);
    bit accepted;
    bit good;
    accepted = 1'b0;
    if (it.op == hls_pkg::OpTick) begin
      if (sup_reboot_cnt != 0) begin
        sup_reboot_cnt = sup_reboot_cnt - 4'd1;
        if (sup_reboot_cnt == 0) begin
          sup_relay  = 1'b1;
          sup_errors = '0;
        end
      end else if (it.heater_on) begin
        sup_fan = 1'b1;
        if (sup_errors >= sup_max_errors) begin
          sup_relay      = 1'b0;
          sup_reboot_cnt = (sup_reboot_len == 0) ? 4'd1 : sup_reboot_len;
        end else begin
          sup_relay = 1'b1;
        end
        sup_runon = '0;
      end else begin
        if (sup_runon <= sup_runon_len) begin
          if (sup_runon != hls_pkg::RunonMax) sup_runon = sup_runon + 16'd1;
        end else begin
          sup_fan = 1'b0;
        end
        sup_relay = 1'b0;
      end
    end else begin
      if (it.frame_start || sup_pos >= hls_pkg::FrameBytes) begin
        sup_pos = 0;
        sup_crc = hls_pkg::CrcInit;
      end
      if (sup_pos < hls_pkg::PayloadLen) begin
        sup_frame[sup_pos] = it.rx_byte;
        sup_crc = crc_next(sup_crc, it.rx_byte);
        sup_pos++;
      end else if (sup_pos == hls_pkg::PayloadLen) begin
        sup_crc_hi = it.rx_byte;
        sup_pos++;
      end else begin
        good    = ({sup_crc_hi, it.rx_byte} == sup_crc);
        sup_pos = 0;
        sup_crc = hls_pkg::CrcInit;
        if (good && sup_frame[0] == sup_dev_addr) begin
          accepted   = 1'b1;
          sup_errors = '0;
          for (int k = 0; k < hls_pkg::PayloadLen; k++) begin
            push_result(hls_pkg::KindPayload, sup_frame[slot_source(k)],
                        k == hls_pkg::PayloadLen - 1, 1'b1);
          end
        end else if (!good) begin
          if (it.heater_on) begin
            if (sup_errors != hls_pkg::ErrMax) sup_errors = sup_errors + 8'd1;
          end else begin
            sup_errors = '0;
          end
        end
      end
    end
    if (!accepted) push_result(hls_pkg::KindStatus, 8'h00, 1'b1, 1'b0);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: %p", out_data_o);
        n_fail++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("kind", oldest_result.kind, out_data_o.kind);
        check_field("payload_byte", oldest_result.payload_byte, out_data_o.payload_byte);
        check_field("last", oldest_result.last, out_data_o.last);
        check_field("frame_accepted", oldest_result.frame_accepted,
                    out_data_o.frame_accepted);
        check_field("error_count", oldest_result.error_count, out_data_o.error_count);
        check_field("fan_on", oldest_result.fan_on, out_data_o.fan_on);
        check_field("relay_on", oldest_result.relay_on, out_data_o.relay_on);
      end
    end
  end

  // receiver backpressure, switching between patterns
  always @(posedge clk_i) begin
    beat_cnt <= beat_cnt + 3'd1;
    if (ready_hold == 0) begin
      ready_mode <= rdy_mode_e'($urandom_range(0, 3));
      ready_hold <= $urandom_range(20, 300);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      RdyAlways: out_ready_i <= 1'b1;
      RdyCoin:   out_ready_i <= 1'($urandom);
      RdySparse: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= (beat_cnt < 3'd3);
    endcase
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_heater_link_supervisor_core: done, errors");
    $finish;
  end

  task automatic send_item(input hls_pkg::hls_in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(it);
    n_sent++;
  endtask

  task automatic send_tick(input logic heat);
    hls_pkg::hls_in_t it;
    it.op          = hls_pkg::OpTick;
    it.rx_byte     = 8'($urandom);
    it.frame_start = 1'($urandom);
    it.heater_on   = heat;
    send_item(it);
  endtask

  // sends the first n_bytes of a frame; ticks may be slipped in between bytes
  task automatic send_frame(input logic [7:0] addr, input int fill, input bit corrupt,
                            input logic heat, input int n_bytes, input bit with_ticks);
    logic [7:0]       fb [hls_pkg::FrameBytes];
    logic [15:0]      crc;
    hls_pkg::hls_in_t it;
    bit               mark;
    int               flip_pos;
    fb[0] = addr;
    for (int i = 1; i < hls_pkg::PayloadLen; i++) begin
      case (fill)
        FillRamp:  fb[i] = 8'(i * 15);
        FillZeros: fb[i] = 8'h00;
        FillOnes:  fb[i] = 8'hFF;
        default:   fb[i] = 8'($urandom);
      endcase
    end
    crc = hls_pkg::CrcInit;
    for (int i = 0; i < hls_pkg::PayloadLen; i++) crc = crc_next(crc, fb[i]);
    fb[hls_pkg::PayloadLen]     = crc[15:8];
    fb[hls_pkg::PayloadLen + 1] = crc[7:0];
    // a single flipped bit always breaks the crc
    if (corrupt) begin
      flip_pos = $urandom_range(0, hls_pkg::FrameBytes - 1);
      fb[flip_pos] = fb[flip_pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    mark = (sup_pos != 0) || ($urandom_range(0, 1) == 1);
    for (int i = 0; i < n_bytes; i++) begin
      if (with_ticks && $urandom_range(0, 7) == 0) send_tick(1'($urandom));
      it.op          = hls_pkg::OpByte;
      it.rx_byte     = fb[i];
      it.frame_start = (i == 0) && mark;
      it.heater_on   = (i == hls_pkg::FrameBytes - 1) ? heat : 1'($urandom);
      send_item(it);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [hls_pkg::CfgIdxW-1:0] idx,
                           input logic [hls_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      hls_pkg::CfgDevAddr:     sup_dev_addr   = data[7:0];
      hls_pkg::CfgMaxErrors:   sup_max_errors = data[7:0];
      hls_pkg::CfgFanRunon:    sup_runon_len  = data;
      hls_pkg::CfgRebootTicks: sup_reboot_len = data[3:0];
      default: ;
    endcase
  endtask

  task automatic test_status_ticks();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_accepted_frame();
    send_frame(sup_dev_addr, FillRamp, 1'b0, 1'b1, hls_pkg::FrameBytes, 1'b0);
    send_frame(sup_dev_addr, FillZeros, 1'b0, 1'b1, hls_pkg::FrameBytes, 1'b0);
    send_frame(sup_dev_addr, FillOnes, 1'b0, 1'b0, hls_pkg::FrameBytes, 1'b0);
  endtask

  task automatic test_crc_errors();
    send_frame(sup_dev_addr, FillRandom, 1'b1, 1'b1, hls_pkg::FrameBytes, 1'b0);
    send_frame(sup_dev_addr, FillRandom, 1'b1, 1'b1, hls_pkg::FrameBytes, 1'b0);
    // heating off clears the count
    send_frame(sup_dev_addr, FillRandom, 1'b1, 1'b0, hls_pkg::FrameBytes, 1'b0);
    send_frame(sup_dev_addr, FillRandom, 1'b1, 1'b1, hls_pkg::FrameBytes, 1'b0);
  endtask

  task automatic test_address_mismatch();
    send_frame(sup_dev_addr + 8'd1, FillRandom, 1'b0, 1'b1, hls_pkg::FrameBytes, 1'b0);
    send_frame(sup_dev_addr, FillRandom, 1'b0, 1'b1, hls_pkg::FrameBytes, 1'b0);
  endtask

  task automatic test_resync();
    send_frame(sup_dev_addr, FillRandom, 1'b0, 1'b1, 7, 1'b0);
    send_frame(sup_dev_addr, FillRandom, 1'b0, 1'b1, hls_pkg::FrameBytes, 1'b1);
  endtask

  task automatic test_reboot();
    wait_idle();
    write_reg(hls_pkg::CfgMaxErrors, 16'd2);
    write_reg(hls_pkg::CfgRebootTicks, 16'd0);
    repeat (2) send_frame(sup_dev_addr, FillRandom, 1'b1, 1'b1, hls_pkg::FrameBytes, 1'b0);
    send_tick(1'b1);
    // errors still count while the relay is held off
    send_frame(sup_dev_addr, FillRandom, 1'b1, 1'b1, hls_pkg::FrameBytes, 1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    wait_idle();
    write_reg(hls_pkg::CfgRebootTicks, 16'd15);
    repeat (2) send_frame(sup_dev_addr, FillRandom, 1'b1, 1'b1, hls_pkg::FrameBytes, 1'b0);
    send_tick(1'b1);
    repeat (17) send_tick(1'($urandom));
  endtask

  task automatic test_fan_runon();
    wait_idle();
    write_reg(hls_pkg::CfgFanRunon, 16'd2);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    send_tick(1'b1);
    wait_idle();
    write_reg(hls_pkg::CfgFanRunon, 16'd0);
    repeat (3) send_tick(1'b0);
  endtask

  task automatic test_random();
    logic [7:0]       addr;
    logic [7:0]       max_err;
    logic [15:0]      runon;
    logic [3:0]       reboot_len;
    int               start;
    int               r;
    hls_pkg::hls_in_t it;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          addr = 8'h00; max_err = 8'd1; runon = 16'd0; reboot_len = 4'd1;
        end
        1: begin
          addr = 8'hFF; max_err = 8'd255; runon = 16'hFFFF; reboot_len = 4'd15;
        end
        2: begin
          addr = 8'($urandom); max_err = 8'd0; runon = 16'd1; reboot_len = 4'd0;
        end
        default: begin
          addr       = 8'($urandom);
          max_err    = 8'($urandom_range(1, 6));
          runon      = 16'($urandom_range(0, 4));
          reboot_len = 4'($urandom_range(1, 4));
        end
      endcase
      // upper data bits are don't-care for the narrow registers
      write_reg(hls_pkg::CfgDevAddr, {8'($urandom), addr});
      write_reg(hls_pkg::CfgMaxErrors, {8'($urandom), max_err});
      write_reg(hls_pkg::CfgFanRunon, runon);
      write_reg(hls_pkg::CfgRebootTicks, {12'($urandom), reboot_len});
      start = n_sent;
      while (n_sent - start < 20) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          send_frame(sup_dev_addr, FillRandom, 1'b0, 1'($urandom), hls_pkg::FrameBytes,
                     $urandom_range(0, 3) == 0);
        end else if (r < 60) begin
          send_frame(8'($urandom), FillRandom, 1'b0, 1'($urandom), hls_pkg::FrameBytes,
                     1'b0);
        end else if (r < 78) begin
          send_frame(sup_dev_addr, FillRandom, 1'b1, $urandom_range(0, 4) != 0,
                     hls_pkg::FrameBytes, $urandom_range(0, 3) == 0);
        end else if (r < 86) begin
          send_frame(sup_dev_addr, FillRandom, 1'b0, 1'($urandom),
                     $urandom_range(1, hls_pkg::FrameBytes - 1), 1'b0);
        end else if (r < 94) begin
          send_tick($urandom_range(0, 3) != 0);
        end else begin
          it.op          = hls_pkg::OpByte;
          it.rx_byte     = 8'($urandom);
          it.frame_start = 1'($urandom);
          it.heater_on   = 1'($urandom);
          send_item(it);
        end
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    n_fail         = 0;
    n_sent         = 0;
    burst_left     = 0;
    sup_dev_addr   = 8'd1;
    sup_max_errors = 8'd5;
    sup_runon_len  = 16'd60;
    sup_reboot_len = 4'd3;
    sup_pos        = 0;
    sup_crc        = hls_pkg::CrcInit;
    sup_crc_hi     = '0;
    sup_errors     = '0;
    sup_runon      = '0;
    sup_fan        = 1'b1;
    sup_relay      = 1'b0;
    sup_reboot_cnt = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_status_ticks();
    test_accepted_frame();
    test_crc_errors();
    test_address_mismatch();
    test_resync();
    test_reboot();
    test_fan_runon();
    test_random();
    wait_idle();

    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("tb_heater_link_supervisor_core: done, clean");
    end else begin
      $display("tb_heater_link_supervisor_core: done, errors");
    end
    $finish;
  end

endmodule
